// ===== rtl/mssd_pkg.sv =====
`default_nettype none
package mssd_pkg;

  localparam int PLACES  = 4;
  localparam int PLACE_W = (PLACES > 1) ? $clog2(PLACES) : 1;
  localparam int STORED  = 4;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_DECIMAL = 3'd1;
  localparam logic [2:0] REQ_TIME    = 3'd2;
  localparam logic [2:0] REQ_HEX     = 3'd3;
  localparam logic [2:0] REQ_RAW     = 3'd4;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;

  typedef struct packed {
    logic              tick;
    logic              load_digits;
    logic              load_raw;
    digit_t [STORED-1:0] digits;
    seg_t   [STORED-1:0] raw;
  } upd_t;

  function automatic seg_t glyph(input logic [3:0] code);
    seg_t g;
    case (code)
      4'h0: g = 8'hFC;
      4'h1: g = 8'h60;
      4'h2: g = 8'hDA;
      4'h3: g = 8'hF2;
      4'h4: g = 8'h66;
      4'h5: g = 8'hB6;
      4'h6: g = 8'hBE;
      4'h7: g = 8'hE0;
      4'h8: g = 8'hFE;
      4'h9: g = 8'hF6;
      4'hA: g = 8'hEE;
      4'hB: g = 8'h3E;
      4'hC: g = 8'h9C;
      4'hD: g = 8'h7A;
      4'hE: g = 8'h9E;
      4'hF: g = 8'h8E;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic seg_t digit_glyph(input digit_t d);
    seg_t g;
    g = (d <= 4'd9) ? glyph(d) : 8'h00;
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mssd_decode.sv =====
`default_nettype none
module mssd_decode (
  input  wire logic [2:0]    req_type,
  input  wire logic [15:0]   number_value,
  input  wire logic [6:0]    hours,
  input  wire logic [6:0]    minutes,
  input  wire mssd_pkg::seg_t place0_segments,
  input  wire mssd_pkg::seg_t place1_segments,
  input  wire mssd_pkg::seg_t place2_segments,
  input  wire mssd_pkg::seg_t place3_segments,
  output mssd_pkg::upd_t     upd
);

  function automatic mssd_pkg::digit_t rem10(input logic [15:0] num, input logic [15:0] quo);
    logic [15:0] r;
    r = num - (quo << 3) - (quo << 1);
    return r[3:0];
  endfunction

  logic [33:0] m10, m100, m1000, m10000;
  logic [12:0] q10;
  logic [9:0]  q100;
  logic [6:0]  q1000;
  logic [2:0]  q10000;
  logic [14:0] mh, mm;
  logic [3:0]  hq, mq;
  mssd_pkg::digit_t [3:0] dec_digits, time_digits;
  mssd_pkg::seg_t   [3:0] hex_raw, given_raw;

  assign m10    = 34'(number_value) * 34'd52429;
  assign m100   = 34'(number_value) * 34'd167773;
  assign m1000  = 34'(number_value) * 34'd67109;
  assign m10000 = 34'(number_value) * 34'd107375;
  assign q10    = m10[31:19];
  assign q100   = m100[33:24];
  assign q1000  = m1000[32:26];
  assign q10000 = m10000[32:30];

  assign dec_digits[3] = rem10(number_value, 16'(q10));
  assign dec_digits[2] = rem10(16'(q10), 16'(q100));
  assign dec_digits[1] = rem10(16'(q100), 16'(q1000));
  assign dec_digits[0] = rem10(16'(q1000), 16'(q10000));

  assign mh = 15'(hours) * 15'd205;
  assign mm = 15'(minutes) * 15'd205;
  assign hq = mh[14:11];
  assign mq = mm[14:11];

  assign time_digits[0] = (hq >= 4'd10) ? hq - 4'd10 : hq;
  assign time_digits[1] = rem10(16'(hours), 16'(hq));
  assign time_digits[2] = (mq >= 4'd10) ? mq - 4'd10 : mq;
  assign time_digits[3] = rem10(16'(minutes), 16'(mq));

  assign hex_raw[0] = mssd_pkg::glyph(number_value[15:12]);
  assign hex_raw[1] = mssd_pkg::glyph(number_value[11:8]);
  assign hex_raw[2] = mssd_pkg::glyph(number_value[7:4]);
  assign hex_raw[3] = mssd_pkg::glyph(number_value[3:0]);

  assign given_raw[0] = place0_segments;
  assign given_raw[1] = place1_segments;
  assign given_raw[2] = place2_segments;
  assign given_raw[3] = place3_segments;

  always_comb begin
    upd.tick        = (req_type == mssd_pkg::REQ_TICK);
    upd.load_digits = (req_type == mssd_pkg::REQ_DECIMAL) || (req_type == mssd_pkg::REQ_TIME);
    upd.load_raw    = (req_type == mssd_pkg::REQ_HEX) || (req_type == mssd_pkg::REQ_RAW);
    upd.digits      = (req_type == mssd_pkg::REQ_TIME) ? time_digits : dec_digits;
    upd.raw         = (req_type == mssd_pkg::REQ_HEX) ? hex_raw : given_raw;
  end

endmodule
`default_nettype wire

// ===== rtl/mssd_store.sv =====
`default_nettype none
module mssd_store (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           apply,
  input  wire mssd_pkg::upd_t upd,
  output mssd_pkg::seg_t      segment,
  output logic [3:0]          enable,
  output logic [1:0]          index
);

  logic [mssd_pkg::PLACE_W-1:0] scan_place, scan_place_next;
  logic                         show_raw_mode;
  mssd_pkg::digit_t [mssd_pkg::STORED-1:0] digit_store;
  mssd_pkg::seg_t   [mssd_pkg::STORED-1:0] raw_store;
  logic [1:0] sel;
  logic       in_range;

  assign scan_place_next = (32'(scan_place) == mssd_pkg::PLACES - 1) ?
                           '0 : scan_place + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_place    <= '0;
      show_raw_mode <= 1'b0;
      digit_store   <= '0;
      raw_store     <= '0;
    end else if (apply) begin
      if (upd.tick) begin
        scan_place <= scan_place_next;
      end
      if (upd.load_digits) begin
        digit_store   <= upd.digits;
        show_raw_mode <= 1'b0;
      end
      if (upd.load_raw) begin
        raw_store     <= upd.raw;
        show_raw_mode <= 1'b1;
      end
    end
  end

  assign sel      = 2'(scan_place);
  assign in_range = 32'(scan_place) < mssd_pkg::STORED;
  assign index    = sel;

  always_comb begin
    if (show_raw_mode) begin
      segment = in_range ? raw_store[sel] : 8'h00;
    end else begin
      segment = mssd_pkg::digit_glyph(in_range ? digit_store[sel] : 4'd0);
    end
    for (int i = 0; i < 4; i++) begin
      enable[i] = (32'(scan_place) == i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multiplexed_seven_segment_driver.sv =====
// Result path: an accepted tick passes the input and result registers; updates give no result.
// Throughput: one beat per cycle, ticks and updates alike, unless out_stall holds a tick.
// Scan and store path: a tick sees every update accepted before it.
// Reset (rst, synchronous): place 0, digit mode, all digits and raw bytes zero, no beats held.
`default_nettype none
module multiplexed_seven_segment_driver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] number_value,
  input  wire logic [6:0]  hours,
  input  wire logic [6:0]  minutes,
  input  wire logic [7:0]  place0_segments,
  input  wire logic [7:0]  place1_segments,
  input  wire logic [7:0]  place2_segments,
  input  wire logic [7:0]  place3_segments,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       segment_byte,
  output logic [3:0]       place_enable,
  output logic [1:0]       place_index
);

  logic        item_valid;
  logic [2:0]  item_req;
  logic [15:0] item_value;
  logic [6:0]  item_hours, item_minutes;
  mssd_pkg::seg_t item_p0, item_p1, item_p2, item_p3;

  mssd_pkg::upd_t upd;
  mssd_pkg::seg_t cur_segment;
  logic [3:0]     cur_enable;
  logic [1:0]     cur_index;
  logic           out_free, advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && (!upd.tick || out_free);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_req     <= req_type;
      item_value   <= number_value;
      item_hours   <= hours;
      item_minutes <= minutes;
      item_p0      <= place0_segments;
      item_p1      <= place1_segments;
      item_p2      <= place2_segments;
      item_p3      <= place3_segments;
    end
  end

  mssd_decode u_decode (
    .req_type        (item_req),
    .number_value    (item_value),
    .hours           (item_hours),
    .minutes         (item_minutes),
    .place0_segments (item_p0),
    .place1_segments (item_p1),
    .place2_segments (item_p2),
    .place3_segments (item_p3),
    .upd             (upd)
  );

  mssd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .apply   (advance),
    .upd     (upd),
    .segment (cur_segment),
    .enable  (cur_enable),
    .index   (cur_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && upd.tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && upd.tick) begin
      segment_byte <= cur_segment;
      place_enable <= cur_enable;
      place_index  <= cur_index;
    end
  end

endmodule
`default_nettype wire

// ===== verif/mssd_checker.sv =====
module mssd_checker
  import mssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] number_value,
  input  logic [6:0]  hours,
  input  logic [6:0]  minutes,
  input  logic [7:0]  place0_segments,
  input  logic [7:0]  place1_segments,
  input  logic [7:0]  place2_segments,
  input  logic [7:0]  place3_segments,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  segment_byte,
  input  logic [3:0]  place_enable,
  input  logic [1:0]  place_index,
  output int          fail_count,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] seg;
    logic [3:0] en;
    logic [1:0] idx;
  } lit_place_t;

  lit_place_t lit_q[$];
  lit_place_t lit_want;
  lit_place_t lit_new;

  logic [1:0] scan_pos;
  logic       raw_mode;
  logic [3:0] digit_mem[4];
  logic [7:0] seg_mem[4];

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  function automatic logic [7:0] glyph_of(input logic [3:0] code);
    logic [7:0] g;
    case (code)
      4'h0: g = 8'hFC;
      4'h1: g = 8'h60;
      4'h2: g = 8'hDA;
      4'h3: g = 8'hF2;
      4'h4: g = 8'h66;
      4'h5: g = 8'hB6;
      4'h6: g = 8'hBE;
      4'h7: g = 8'hE0;
      4'h8: g = 8'hFE;
      4'h9: g = 8'hF6;
      4'hA: g = 8'hEE;
      4'hB: g = 8'h3E;
      4'hC: g = 8'h9C;
      4'hD: g = 8'h7A;
      4'hE: g = 8'h9E;
      default: g = 8'h8E;
    endcase
    return g;
  endfunction

  task automatic report(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_display();
    scan_pos = '0;
    raw_mode = 1'b0;
    for (int i = 0; i < 4; i++) begin
      digit_mem[i] = '0;
      seg_mem[i]   = '0;
    end
    lit_q.delete();
  endtask

  task automatic apply_request();
    int v;
    int h;
    int m;
    v = number_value;
    h = hours;
    m = minutes;
    case (req_type)
      REQ_TICK: begin
        lit_new.seg = raw_mode ? seg_mem[scan_pos] : glyph_of(digit_mem[scan_pos]);
        lit_new.en  = 4'b0001 << scan_pos;
        lit_new.idx = scan_pos;
        lit_q.push_back(lit_new);
        scan_pos = 2'((scan_pos + 1) % PLACES);
      end
      REQ_DECIMAL: begin
        digit_mem[0] = 4'((v / 1000) % 10);
        digit_mem[1] = 4'((v / 100) % 10);
        digit_mem[2] = 4'((v / 10) % 10);
        digit_mem[3] = 4'(v % 10);
        raw_mode = 1'b0;
      end
      REQ_TIME: begin
        digit_mem[0] = 4'((h / 10) % 10);
        digit_mem[1] = 4'(h % 10);
        digit_mem[2] = 4'((m / 10) % 10);
        digit_mem[3] = 4'(m % 10);
        raw_mode = 1'b0;
      end
      REQ_HEX: begin
        seg_mem[0] = glyph_of(number_value[15:12]);
        seg_mem[1] = glyph_of(number_value[11:8]);
        seg_mem[2] = glyph_of(number_value[7:4]);
        seg_mem[3] = glyph_of(number_value[3:0]);
        raw_mode = 1'b1;
      end
      REQ_RAW: begin
        seg_mem[0] = place0_segments;
        seg_mem[1] = place1_segments;
        seg_mem[2] = place2_segments;
        seg_mem[3] = place3_segments;
        raw_mode = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_display();
    end else begin
      if (out_valid && !out_stall) begin
        if (lit_q.size() == 0) begin
          report($sformatf("unexpected beat seg %h en %b idx %0d",
                           segment_byte, place_enable, place_index));
        end else begin
          lit_want = lit_q.pop_front();
          if (segment_byte !== lit_want.seg)
            report($sformatf("segment_byte %h, want %h", segment_byte, lit_want.seg));
          if (place_enable !== lit_want.en)
            report($sformatf("place_enable %b, want %b", place_enable, lit_want.en));
          if (place_index !== lit_want.idx)
            report($sformatf("place_index %0d, want %0d", place_index, lit_want.idx));
        end
      end
      if (in_valid && !in_stall) apply_request();
    end
    awaiting <= lit_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mssd_pkg::*;

  localparam int ITEMS          = 1400;
  localparam int PHASES         = 4;
  localparam int MAX_GAP        = 18;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = REQ_TICK;
  logic [15:0] number_value = '0;
  logic [6:0]  hours = '0;
  logic [6:0]  minutes = '0;
  logic [7:0]  place0_segments = '0;
  logic [7:0]  place1_segments = '0;
  logic [7:0]  place2_segments = '0;
  logic [7:0]  place3_segments = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  segment_byte;
  logic [3:0]  place_enable;
  logic [1:0]  place_index;

  int mismatches;
  int awaiting;
  int idle_cycles = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  multiplexed_seven_segment_driver u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .number_value    (number_value),
    .hours           (hours),
    .minutes         (minutes),
    .place0_segments (place0_segments),
    .place1_segments (place1_segments),
    .place2_segments (place2_segments),
    .place3_segments (place3_segments),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .segment_byte    (segment_byte),
    .place_enable    (place_enable),
    .place_index     (place_index)
  );

  mssd_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .number_value    (number_value),
    .hours           (hours),
    .minutes         (minutes),
    .place0_segments (place0_segments),
    .place1_segments (place1_segments),
    .place2_segments (place2_segments),
    .place3_segments (place3_segments),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .segment_byte    (segment_byte),
    .place_enable    (place_enable),
    .place_index     (place_index),
    .fail_count      (mismatches),
    .awaiting        (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic drive_request(input logic [2:0] kind, input logic [15:0] value,
                               input logic [6:0] hr, input logic [6:0] mn,
                               input logic [31:0] raw);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= kind;
    number_value    <= value;
    hours           <= hr;
    minutes         <= mn;
    place0_segments <= raw[31:24];
    place1_segments <= raw[23:16];
    place2_segments <= raw[15:8];
    place3_segments <= raw[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) drive_request(REQ_TICK, 16'($urandom), 7'($urandom), 7'($urandom), $urandom);
  endtask

  task automatic send_random_item();
    int pick;
    logic [2:0] kind;
    logic [15:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 55) kind = REQ_TICK;
    else if (pick < 65) kind = REQ_DECIMAL;
    else if (pick < 75) kind = REQ_TIME;
    else if (pick < 85) kind = REQ_HEX;
    else if (pick < 97) kind = REQ_RAW;
    else kind = 3'($urandom_range(REQ_RAW + 1, 7));
    if (kind == REQ_DECIMAL && $urandom_range(0, 3) != 0)
      value = 16'($urandom_range(0, 9999));
    else
      value = 16'($urandom);
    drive_request(kind, value, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                  $urandom);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    int wait_n;
    forever begin
      wait_n = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_ticks(4);
    drive_request(REQ_DECIMAL, 16'hFFFF, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    drive_request(REQ_DECIMAL, 16'd9999, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    drive_request(REQ_TIME, 16'h0, 7'd99, 7'd99, 32'h0);
    send_ticks(1);
    drive_request(REQ_HEX, 16'h89AB, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    drive_request(REQ_RAW, 16'h0, 7'd0, 7'd0, 32'hFF00A55A);
    send_ticks(1);
    drive_request(3'(REQ_RAW + 1), 16'hFFFF, 7'd99, 7'd99, 32'hFFFFFFFF);
    drive_request(3'(REQ_RAW + 2), 16'h1234, 7'd12, 7'd34, 32'h12345678);
    drive_request(3'd7, 16'h0, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    drive_request(REQ_DECIMAL, 16'd0, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    drive_request(REQ_HEX, 16'hCDEF, 7'd0, 7'd0, 32'h0);
    send_ticks(1);
    hold_until_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph == 0 || ph == 2);
      recv_idle = (ph == 0 || ph == 3);
      repeat (ITEMS / PHASES) send_random_item();
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
